### src/assert_macros.svh
// Assertion helpers. The including module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define DFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define DFE_ASSERT_NEVER(lbl, cond, msg) \
  `DFE_ASSERT(lbl, !(cond), msg)

`endif

### src/dfe_pkg.sv
package dfe_pkg;

  localparam int unsigned CmdQueueDepth = 2;

  localparam int unsigned CharW = 8;
  localparam int unsigned CodeW = 27;

  // year = (code * YearRecip) >> YearShift, exact for every 27-bit code.
  localparam logic [26:0] YearRecip  = 27'd109951163;
  localparam int unsigned YearShift  = 40;
  localparam logic [13:0] YearDiv    = 14'd10000;
  // month = (rem * MonthRecip) >> MonthShift, exact for rem below 10000.
  localparam logic [12:0] MonthRecip = 13'd5243;
  localparam int unsigned MonthShift = 19;
  localparam logic [13:0] MonthDiv   = 14'd100;
  // quotient by ten for any 14-bit value.
  localparam logic [14:0] DigRecip   = 15'd26215;
  localparam int unsigned DigShift   = 18;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpY     = 8'h59;
  localparam logic [7:0] ChLowY    = 8'h79;
  localparam logic [7:0] ChLowM    = 8'h6d;
  localparam logic [7:0] ChLowD    = 8'h64;
  localparam logic [7:0] ChUpD     = 8'h44;
  localparam logic [7:0] ChUpM     = 8'h4d;

  typedef enum logic [2:0] {
    K_LIT,
    K_YEAR4,
    K_YEAR2,
    K_MON2,
    K_DAY2,
    K_DAYSFX,
    K_MONNAME
  } cmd_kind_e;

  typedef enum logic [1:0] {
    SFX_ST,
    SFX_ND,
    SFX_RD,
    SFX_TH
  } sfx_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [CharW-1:0] ch;
    logic [CodeW-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pending;
  } fe_stat_t;

  // Month names, left aligned and padded with blanks to nine bytes.
  function automatic logic [71:0] month_bytes(input logic [6:0] m);
    logic [71:0] r;
    case (m)
      7'd1:    r = "January  ";
      7'd2:    r = "February ";
      7'd3:    r = "March    ";
      7'd4:    r = "April    ";
      7'd5:    r = "May      ";
      7'd6:    r = "June     ";
      7'd7:    r = "July     ";
      7'd8:    r = "August   ";
      7'd9:    r = "September";
      7'd10:   r = "October  ";
      7'd11:   r = "November ";
      7'd12:   r = "December ";
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] month_len(input logic [6:0] m);
    logic [3:0] r;
    case (m)
      7'd1:    r = 4'd7;
      7'd2:    r = 4'd8;
      7'd3:    r = 4'd5;
      7'd4:    r = 4'd5;
      7'd5:    r = 4'd3;
      7'd6:    r = 4'd4;
      7'd7:    r = 4'd4;
      7'd8:    r = 4'd6;
      7'd9:    r = 4'd9;
      7'd10:   r = 4'd7;
      7'd11:   r = 4'd8;
      7'd12:   r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] month_char(input logic [6:0] m, input logic [3:0] p);
    logic [71:0] name;
    logic [6:0]  base;
    name = month_bytes(m);
    base = {4'd8 - p, 3'b000};
    return name[base +: 8];
  endfunction

  function automatic logic [7:0] suffix_char(input sfx_e s, input logic p);
    logic [7:0] r;
    case (s)
      SFX_ST:  r = p ? 8'h74 : 8'h73;
      SFX_ND:  r = p ? 8'h64 : 8'h6e;
      SFX_RD:  r = p ? 8'h64 : 8'h72;
      default: r = p ? 8'h68 : 8'h74;
    endcase
    return r;
  endfunction

endpackage

### src/dfe_if.sv
interface dfe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  format_char;
  logic        is_last_char;
  logic [26:0] date_code;

  modport source (output valid, output format_char, output is_last_char,
                  output date_code, input ready);
  modport sink (input valid, input format_char, input is_last_char,
                input date_code, output ready);
endinterface

interface dfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink (input valid, input out_char, input run_last, output ready);
endinterface

### src/dfe_front.sv
module dfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  dfe_in_if.sink            in_i,
  input  dfe_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output dfe_pkg::cmd_t     cmd_o,
  output dfe_pkg::fe_stat_t stat_o
);

  logic pending_q, pending_d;
  logic accept;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    pending_d  = pending_q;
    push_o     = 1'b0;
    cmd_o.kind = dfe_pkg::K_LIT;
    cmd_o.ch   = in_i.format_char;
    cmd_o.code = in_i.date_code;
    if (pending_q) begin
      unique case (in_i.format_char)
        dfe_pkg::ChUpY:  cmd_o.kind = dfe_pkg::K_YEAR4;
        dfe_pkg::ChLowY: cmd_o.kind = dfe_pkg::K_YEAR2;
        dfe_pkg::ChLowM: cmd_o.kind = dfe_pkg::K_MON2;
        dfe_pkg::ChLowD: cmd_o.kind = dfe_pkg::K_DAY2;
        dfe_pkg::ChUpD:  cmd_o.kind = dfe_pkg::K_DAYSFX;
        dfe_pkg::ChUpM:  cmd_o.kind = dfe_pkg::K_MONNAME;
        default:         cmd_o.kind = dfe_pkg::K_LIT;
      endcase
    end
    if (accept) begin
      if (pending_q) begin
        pending_d = 1'b0;
        push_o    = 1'b1;
      end else if (in_i.format_char == dfe_pkg::ChPercent && !in_i.is_last_char) begin
        // A specifier opens: nothing goes to the queue for this word.
        pending_d = 1'b1;
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

  assign stat_o.pending = pending_q;

endmodule

### src/dfe_cmd_fifo.sv
module dfe_cmd_fifo #(
  parameter int unsigned DEPTH = dfe_pkg::CmdQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dfe_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output dfe_pkg::cmd_t    cmd_o,
  output dfe_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dfe_pkg::cmd_t    mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/dfe_back.sv
module dfe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dfe_pkg::cmd_t    cmd_i,
  input  dfe_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  dfe_out_if.source        out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_YEAR = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_MON  = 3'd3;
  localparam logic [2:0] ST_DAY  = 3'd4;
  localparam logic [2:0] ST_CONV = 3'd5;
  localparam logic [2:0] ST_DIG  = 3'd6;
  localparam logic [2:0] ST_TEXT = 3'd7;

  logic [2:0]          state_q, state_d;
  dfe_pkg::cmd_kind_e  kind_q, kind_d;
  logic [26:0]         code_q, code_d;
  logic [13:0]         year_q, year_d;
  logic [13:0]         rem_q, rem_d;
  logic [6:0]          month_q, month_d;
  logic [6:0]          day_q, day_d;
  logic [13:0]         v_q, v_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [2:0]          mind_q, mind_d;
  logic [3:0]          pos_q, pos_d;
  logic [3:0]          dig_q [5];
  logic [3:0]          dig_d [5];
  logic                ov_q, ov_d;
  logic [7:0]          och_q, och_d;
  logic                olast_q, olast_d;

  logic                can_emit;
  logic [53:0]         yprod;
  logic [27:0]         ymul;
  logic [26:0]         mprod;
  logic [28:0]         cprod;
  logic [10:0]         quo;
  logic [3:0]          digit;
  logic [2:0]          ndig;
  logic [2:0]          pos_start;
  logic [3:0]          text_len;
  dfe_pkg::sfx_e       sfx;

  assign can_emit = !ov_q || out_o.ready;

  assign yprod = 54'(code_q) * 54'(dfe_pkg::YearRecip);
  assign ymul  = 28'(year_q) * 28'(dfe_pkg::YearDiv);
  assign mprod = 27'(rem_q) * 27'(dfe_pkg::MonthRecip);
  assign cprod = 29'(v_q) * 29'(dfe_pkg::DigRecip);
  assign quo   = cprod[28:dfe_pkg::DigShift];
  assign digit = 4'(v_q - 14'(quo) * 14'd10);
  assign ndig  = cnt_q + 3'd1;

  always_comb begin
    if (kind_q == dfe_pkg::K_YEAR2) begin
      pos_start = 3'd1;
    end else if (ndig > mind_q) begin
      pos_start = ndig - 3'd1;
    end else begin
      pos_start = mind_q - 3'd1;
    end
  end

  // The first converted digit of the day is day mod ten.
  always_comb begin
    if (day_q >= 7'd11 && day_q <= 7'd13) begin
      sfx = dfe_pkg::SFX_TH;
    end else begin
      case (dig_q[0])
        4'd1:    sfx = dfe_pkg::SFX_ST;
        4'd2:    sfx = dfe_pkg::SFX_ND;
        4'd3:    sfx = dfe_pkg::SFX_RD;
        default: sfx = dfe_pkg::SFX_TH;
      endcase
    end
  end

  assign text_len = (kind_q == dfe_pkg::K_MONNAME) ? dfe_pkg::month_len(month_q) : 4'd2;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    code_d  = code_q;
    year_d  = year_q;
    rem_d   = rem_q;
    month_d = month_q;
    day_d   = day_q;
    v_d     = v_q;
    cnt_d   = cnt_q;
    mind_d  = mind_q;
    pos_d   = pos_q;
    dig_d   = dig_q;
    och_d   = och_q;
    olast_d = olast_q;
    ov_d    = ov_q && !out_o.ready;
    pop_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          if (cmd_i.kind == dfe_pkg::K_LIT) begin
            if (can_emit) begin
              pop_o   = 1'b1;
              ov_d    = 1'b1;
              och_d   = cmd_i.ch;
              olast_d = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            kind_d  = cmd_i.kind;
            code_d  = cmd_i.code;
            state_d = ST_YEAR;
          end
        end
      end
      ST_YEAR: begin
        year_d  = yprod[53:dfe_pkg::YearShift];
        state_d = ST_REM;
      end
      ST_REM: begin
        rem_d   = 14'(code_q - ymul[26:0]);
        state_d = ST_MON;
      end
      ST_MON: begin
        month_d = mprod[25:dfe_pkg::MonthShift];
        state_d = ST_DAY;
      end
      ST_DAY: begin
        day_d = 7'(rem_q - 14'(month_q) * dfe_pkg::MonthDiv);
        for (int i = 0; i < 5; i++) begin
          dig_d[i] = '0;
        end
        cnt_d   = '0;
        state_d = ST_CONV;
        case (kind_q)
          dfe_pkg::K_YEAR4: begin
            v_d    = year_q;
            mind_d = 3'd4;
          end
          dfe_pkg::K_YEAR2: begin
            v_d    = year_q;
            mind_d = 3'd2;
          end
          dfe_pkg::K_MON2: begin
            v_d    = 14'(month_q);
            mind_d = 3'd2;
          end
          dfe_pkg::K_DAY2: begin
            v_d    = 14'(day_d);
            mind_d = 3'd2;
          end
          dfe_pkg::K_DAYSFX: begin
            v_d    = 14'(day_d);
            mind_d = 3'd1;
          end
          default: begin
            // Month name: no digits; an out-of-range month produces no word.
            v_d    = '0;
            mind_d = 3'd1;
            pos_d  = '0;
            if (month_q >= 7'd1 && month_q <= 7'd12) begin
              state_d = ST_TEXT;
            end else begin
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_CONV: begin
        dig_d[cnt_q] = digit;
        if (quo == '0) begin
          pos_d   = 4'(pos_start);
          state_d = ST_DIG;
        end else begin
          v_d   = 14'(quo);
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_DIG: begin
        if (can_emit) begin
          ov_d    = 1'b1;
          och_d   = dfe_pkg::ChZero + 8'(dig_q[pos_q[2:0]]);
          olast_d = (pos_q == '0) && (kind_q != dfe_pkg::K_DAYSFX);
          if (pos_q == '0) begin
            state_d = (kind_q == dfe_pkg::K_DAYSFX) ? ST_TEXT : ST_IDLE;
          end else begin
            pos_d = pos_q - 4'd1;
          end
        end
      end
      ST_TEXT: begin
        if (can_emit) begin
          ov_d  = 1'b1;
          och_d = (kind_q == dfe_pkg::K_MONNAME) ? dfe_pkg::month_char(month_q, pos_q)
                                                 : dfe_pkg::suffix_char(sfx, pos_q[0]);
          olast_d = (pos_q == text_len - 4'd1);
          if (pos_q == text_len - 4'd1) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    code_q  <= code_d;
    year_q  <= year_d;
    rem_q   <= rem_d;
    month_q <= month_d;
    day_q   <= day_d;
    v_q     <= v_d;
    cnt_q   <= cnt_d;
    mind_q  <= mind_d;
    pos_q   <= pos_d;
    dig_q   <= dig_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_char = och_q;
  assign out_o.run_last = olast_q;

endmodule

### src/date_format_expander_top.sv
// Date format expander: takes one format-string byte per input word together
// with a date coded as year*10000 + month*100 + day, and writes the expanded
// text one byte per output word, with run_last set on the last byte of each
// input word. The front end takes one input word per cycle while the command
// queue has room; an opening '%' is absorbed there and produces no output.
// Plain bytes leave the back end one per cycle unless the output stalls.
// A specifier leaves the queue, then the back end splits the date in ST_YEAR,
// ST_REM, ST_MON and ST_DAY (reciprocal multiplies for /10000 and /100),
// converts its decimal digits in ST_CONV (a multiply by the reciprocal of
// ten) and emits its bytes from ST_DIG and ST_TEXT. The back end takes no new
// command until it is done with the last one, and this serial back end sets
// the sustained rate.
`include "assert_macros.svh"

module date_format_expander_top #(
  parameter int unsigned QUEUE_DEPTH = dfe_pkg::CmdQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfe_in_if.sink     in_i,
  dfe_out_if.source  out_o
);

  logic              push;
  logic              pop;
  dfe_pkg::cmd_t     cmd_in;
  dfe_pkg::cmd_t     cmd_head;
  dfe_pkg::q_stat_t  q_stat;
  dfe_pkg::fe_stat_t fe_stat;
  logic              in_acc;
  logic              pct_open;

  dfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (cmd_in),
    .stat_o   (fe_stat)
  );

  dfe_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_head),
    .stat_o (q_stat)
  );

  dfe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign pct_open = in_acc && !fe_stat.pending && (in_i.format_char == dfe_pkg::ChPercent)
                    && !in_i.is_last_char;

  `DFE_ASSERT(a_pct_arms, pct_open |=> fe_stat.pending, "opening percent did not arm")
  `DFE_ASSERT(a_spec_clears, (in_acc && fe_stat.pending) |=> !fe_stat.pending,
              "specifier byte left percent pending")
  `DFE_ASSERT_NEVER(a_push_full, push && q_stat.full, "command pushed into full queue")
  `DFE_ASSERT_NEVER(a_pop_empty, pop && q_stat.empty, "command popped from empty queue")

endmodule
